[src/psb_pkg.sv]
// Package for the prime sieve bitmap block.
// Sizes, FSM state type and the structs shared by the sieve modules.
`default_nettype none

package psb_pkg;

    localparam int MAX_N       = 4096;
    localparam int WORD_BITS   = 64;
    localparam int STORE_WORDS = (MAX_N + WORD_BITS - 1) / WORD_BITS;
    localparam int NUM_W       = 13;
    localparam int WADDR_W     = $clog2(STORE_WORDS);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BASE_W      = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_BASE_RD,
        ST_BASE_CHK,
        ST_CROSS,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic                 we;
        logic [WADDR_W-1:0]   waddr;
        logic [WORD_BITS-1:0] wdata;
    } ram_wr_t;

    typedef struct packed {
        logic                 valid;
        logic [WADDR_W-1:0]   word_index;
        logic [WORD_BITS-1:0] prime_mask;
        logic                 last;
    } emit_t;

endpackage

`default_nettype wire

[src/psb_req_if.sv]
// Request channel of the prime sieve bitmap block: valid/ready plus the limit.
// Depends on psb_pkg.
`default_nettype none

interface psb_req_if
    import psb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

`default_nettype wire

[src/psb_rsp_if.sv]
// Result channel of the prime sieve bitmap block: valid/ready plus one bitmap word.
// Depends on psb_pkg.
`default_nettype none

interface psb_rsp_if
    import psb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [WADDR_W-1:0]   word_index;
    logic [WORD_BITS-1:0] prime_mask;
    logic                 last;

    modport source (output valid, output word_index, output prime_mask, output last,
                    input ready);
    modport sink   (input valid, input word_index, input prime_mask, input last,
                    output ready);
endinterface

`default_nettype wire

[src/psb_flag_ram.sv]
// Flag store: one-write, one-read synchronous RAM with a registered read.
// A read that hits the word written in the same cycle returns the new data.
// Depends on psb_pkg.
`default_nettype none

module psb_flag_ram
    import psb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ram_wr_t              wr,
    input  wire logic [WADDR_W-1:0]   raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [STORE_WORDS];
    logic [WORD_BITS-1:0] rd_reg;
    logic [WORD_BITS-1:0] byp_data_reg;
    logic                 byp_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        rd_reg       <= mem[raddr];
        byp_data_reg <= wr.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            byp_valid_reg <= wr.we && (wr.waddr == raddr);
        end
    end

    assign rdata = byp_valid_reg ? byp_data_reg : rd_reg;

endmodule

`default_nettype wire

[src/psb_sieve_ctrl.sv]
// Sieve sequencer: store init, base scan, pipelined read-modify-write crossing
// and bitmap readout. Drives psb_flag_ram; depends on psb_pkg.
`default_nettype none

module psb_sieve_ctrl
    import psb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic [NUM_W-1:0]     req_limit,
    input  wire logic                 out_free,
    output emit_t                     emit,
    output ram_wr_t                   wr,
    output logic      [WADDR_W-1:0]   raddr,
    input  wire logic [WORD_BITS-1:0] rdata
);

    state_t               state_reg, state_next;
    logic [NUM_W-1:0]     n_reg, n_next;
    logic [BASE_W-1:0]    b_reg, b_next;
    logic [NUM_W-1:0]     c_reg, c_next;
    logic [WADDR_W-1:0]   k_reg, k_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [WADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [BIT_W-1:0]     pend_bit_reg, pend_bit_next;

    logic [2*BASE_W-1:0]  b_sq;
    logic                 base_live;
    logic                 base_prime;
    logic                 cross_issue;
    logic [NUM_W-1:0]     n_clamped;
    logic [WADDR_W-1:0]   last_k;
    logic [NUM_W-1:0]     n_minus1;
    logic [WORD_BITS-1:0] tail_mask;

    assign b_sq        = b_reg * b_reg;
    assign base_live   = b_sq < {{(2*BASE_W-NUM_W){1'b0}}, n_reg};
    assign base_prime  = rdata[b_reg[BIT_W-1:0]];
    assign cross_issue = c_reg < n_reg;
    assign n_minus1    = n_reg - NUM_W'(1);
    assign last_k      = WADDR_W'(n_minus1 >> BIT_W);
    assign tail_mask   = (n_reg[BIT_W-1:0] == '0) ? '1
                       : ((WORD_BITS'(1) << n_reg[BIT_W-1:0]) - WORD_BITS'(1));

    always_comb
    begin
        if (req_limit < NUM_W'(2))
            n_clamped = NUM_W'(2);
        else if (req_limit > NUM_W'(MAX_N))
            n_clamped = NUM_W'(MAX_N);
        else
            n_clamped = req_limit;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = ST_INIT;
            ST_INIT:
                if (k_reg == WADDR_W'(STORE_WORDS - 1))
                    state_next = ST_BASE_RD;
            ST_BASE_RD:
                state_next = base_live ? ST_BASE_CHK : ST_EMIT_RD;
            ST_BASE_CHK:
                state_next = base_prime ? ST_CROSS : ST_BASE_RD;
            ST_CROSS:
                if (!cross_issue && !pend_valid_reg)
                    state_next = ST_BASE_RD;
            ST_EMIT_RD:
                if (out_free)
                    state_next = ST_EMIT_LD;
            ST_EMIT_LD:
                state_next = (k_reg == last_k) ? ST_IDLE : ST_EMIT_RD;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_ready       = 1'b0;
        emit            = '0;
        wr              = '0;
        raddr           = k_reg;
        n_next          = n_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_bit_next   = pend_bit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    n_next = n_clamped;
                    k_next = '0;
                end
            end
            ST_INIT:
            begin
                wr.we    = 1'b1;
                wr.waddr = k_reg;
                wr.wdata = (k_reg == '0) ? ~WORD_BITS'(3) : '1;
                k_next   = k_reg + WADDR_W'(1);
                b_next   = BASE_W'(2);
            end
            ST_BASE_RD:
            begin
                raddr  = WADDR_W'(b_reg >> BIT_W);
                k_next = '0;
            end
            ST_BASE_CHK:
            begin
                c_next = NUM_W'(b_sq);
                if (!base_prime)
                    b_next = b_reg + BASE_W'(1);
            end
            ST_CROSS:
            begin
                raddr    = WADDR_W'(c_reg >> BIT_W);
                wr.we    = pend_valid_reg;
                wr.waddr = pend_addr_reg;
                wr.wdata = rdata & ~(WORD_BITS'(1) << pend_bit_reg);
                if (cross_issue)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = WADDR_W'(c_reg >> BIT_W);
                    pend_bit_next   = c_reg[BIT_W-1:0];
                    c_next          = c_reg + NUM_W'(b_reg);
                end
                else if (!pend_valid_reg)
                begin
                    b_next = b_reg + BASE_W'(1);
                end
            end
            ST_EMIT_RD:
            begin
                raddr = k_reg;
            end
            ST_EMIT_LD:
            begin
                emit.valid      = 1'b1;
                emit.word_index = k_reg;
                emit.last       = (k_reg == last_k);
                emit.prime_mask = (k_reg == last_k) ? (rdata & tail_mask) : rdata;
                k_next          = k_reg + WADDR_W'(1);
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= NUM_W'(2);
            b_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            b_reg          <= b_next;
            c_reg          <= c_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_bit_reg  <= pend_bit_next;
    end

    a_cross_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CROSS && pend_valid_reg)
            |-> (NUM_W'({pend_addr_reg, pend_bit_reg}) < n_reg))
        else $error("crossing write beyond limit");

    a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        emit.valid |-> ($past(state_reg) == ST_EMIT_RD))
        else $error("bitmap word without a preceding read");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after last word");

endmodule

`default_nettype wire

[src/prime_sieve_bitmap.sv]
// Prime sieve bitmap: one limit in, ceil(n/64) prime bitmap words out.
// A request is taken in idle, all 64 words of the flag RAM are initialized,
// then each candidate base is read and checked; a prime base crosses its
// multiples with one RAM read-modify-write per cycle, pipelined through the
// single RAM port pair, and then drains that pipeline. The scan then closes,
// and each output word is read once the output register is free and then
// loaded into it. The RAM port is the limit throughout. A new limit is taken
// only once the previous run's last word sits in the output register.
// Depends on psb_pkg, psb_req_if, psb_rsp_if, psb_flag_ram, psb_sieve_ctrl.
`default_nettype none

module prime_sieve_bitmap
    import psb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    psb_req_if.sink    req,
    psb_rsp_if.source  rsp
);

    emit_t                emit;
    ram_wr_t              wr;
    logic [WADDR_W-1:0]   raddr;
    logic [WORD_BITS-1:0] rdata;
    logic                 out_free;

    logic                 out_valid_reg;
    logic [WADDR_W-1:0]   out_index_reg;
    logic [WORD_BITS-1:0] out_mask_reg;
    logic                 out_last_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    psb_sieve_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_limit (req.limit),
        .out_free  (out_free),
        .emit      (emit),
        .wr        (wr),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    psb_flag_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_index_reg <= emit.word_index;
            out_mask_reg  <= emit.prime_mask;
            out_last_reg  <= emit.last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.word_index = out_index_reg;
    assign rsp.prime_mask = out_mask_reg;
    assign rsp.last       = out_last_reg;

endmodule

`default_nettype wire
